[rtl/skt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pkg: shared types and codes of the sorted key table
// Field widths, operation and status codes, and the per-cell control struct.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int CAPACITY_DEF = 32;

  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 24;
  localparam int AGE_W    = 8;
  localparam int KIDS_W   = 8;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 5;
  localparam int CNT_W    = 6;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  // cell update commands
  localparam logic [1:0] CMD_HOLD   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [AGE_W-1:0]  age;
    logic [KIDS_W-1:0] kids;
  } rec_t;

  typedef struct packed {
    logic [1:0] cmd;
    rec_t       rec;
  } cell_ctl_t;

endpackage

[rtl/skt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_cell: one slot of the sorted table
// Holds one record, compares it with the request key and shifts with its
// neighbors on insert and delete.
// ----------------------------------------------------------------------------
module skt_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 6
) (
  input  logic                    clk,
  input  logic [skt_pkg::KEY_W-1:0] search_key,
  input  logic [CW-1:0]           count,
  input  skt_pkg::cell_ctl_t      ctl,
  input  logic                    less_prev,
  input  skt_pkg::rec_t           lower_rec,
  input  skt_pkg::rec_t           upper_rec,
  output skt_pkg::rec_t           rec,
  output logic                    less,
  output logic                    eq,
  output logic                    bound
);

  logic valid;

  assign valid = CW'(INDEX) < count;
  assign less  = valid && (rec.key < search_key);
  assign eq    = valid && (rec.key == search_key);
  // first slot whose key is not below the request key
  assign bound = less_prev && !less;

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      skt_pkg::CMD_INSERT: begin
        if (bound) begin
          rec <= ctl.rec;
        end else if (!less_prev) begin
          rec <= lower_rec;
        end
      end
      skt_pkg::CMD_DELETE: begin
        if (!less) begin
          rec <= upper_rec;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/sorted_key_table_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_unit: sorted record table built as a chain of slot cells
// A request is captured on accept; one compare-and-shift step across all cells
// then sets the result, unless a stalled result holds that step back. The busy
// flag holds s_tready low while a request is held, so one request is taken at a time.
// Reset clears the fill count and handshake state; slot contents are not
// cleared and only slots below the fill count are ever compared.
// ----------------------------------------------------------------------------
module sorted_key_table_unit #(
  parameter int CAPACITY = skt_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // search_key[23:0], age[31:24], children_count[39:32]
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // position[4:0], count_after[10:5], zero[15:11]
  output logic [1:0]  m_tuser    // status[1:0]
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = (CW > skt_pkg::CNT_W) ? CW : skt_pkg::CNT_W;

  logic                           busy;
  logic [skt_pkg::FUNC_W-1:0]     req_func;
  skt_pkg::rec_t                  req_rec;
  logic [CW-1:0]                  count;
  logic [CW-1:0]                  count_next;

  skt_pkg::rec_t                  recs   [CAPACITY];
  logic [CAPACITY-1:0]            lesses;
  logic [CAPACITY-1:0]            eqs;
  logic [CAPACITY-1:0]            bounds;
  skt_pkg::cell_ctl_t             ctl;

  logic                           eval;
  logic                           found;
  logic                           full;
  logic [EW-1:0]                  pos_ext;
  logic [EW-1:0]                  cnt_ext;
  logic [skt_pkg::STATUS_W-1:0]   status_next;
  logic [skt_pkg::POS_W-1:0]      pos_next;
  logic [skt_pkg::STATUS_W-1:0]   out_status;
  logic [skt_pkg::POS_W-1:0]      out_pos;
  logic [skt_pkg::CNT_W-1:0]      out_cnt;

  assign s_tready = !busy;
  assign eval     = busy && (!m_tvalid || m_tready);

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      skt_cell #(
        .INDEX(g),
        .CW   (CW)
      ) u_cell (
        .clk       (clk),
        .search_key(req_rec.key),
        .count     (count),
        .ctl       (ctl),
        .less_prev ((g == 0) ? 1'b1 : lesses[(g == 0) ? 0 : g - 1]),
        .lower_rec ((g == 0) ? req_rec : recs[(g == 0) ? 0 : g - 1]),
        .upper_rec ((g == CAPACITY - 1) ? recs[g] : recs[(g == CAPACITY - 1) ? g : g + 1]),
        .rec       (recs[g]),
        .less      (lesses[g]),
        .eq        (eqs[g]),
        .bound     (bounds[g])
      );
    end
  endgenerate

  assign found = |eqs;
  assign full  = count >= CW'(CAPACITY);

  // encode the single boundary slot
  always_comb begin
    pos_ext = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (bounds[i]) begin
        pos_ext = pos_ext | EW'(i);
      end
    end
  end

  always_comb begin
    ctl.rec     = req_rec;
    ctl.cmd     = skt_pkg::CMD_HOLD;
    status_next = skt_pkg::ST_OK;
    pos_next    = '0;
    count_next  = count;
    case (req_func)
      skt_pkg::FUNC_INSERT: begin
        if (full) begin
          status_next = skt_pkg::ST_FULL;
        end else if (found) begin
          status_next = skt_pkg::ST_DUPLICATE;
          pos_next    = pos_ext[skt_pkg::POS_W-1:0];
        end else begin
          ctl.cmd    = skt_pkg::CMD_INSERT;
          pos_next   = pos_ext[skt_pkg::POS_W-1:0];
          count_next = count + CW'(1);
        end
      end
      skt_pkg::FUNC_LOOKUP: begin
        if (found) begin
          pos_next = pos_ext[skt_pkg::POS_W-1:0];
        end else begin
          status_next = skt_pkg::ST_NOT_FOUND;
        end
      end
      skt_pkg::FUNC_DELETE: begin
        if (found) begin
          ctl.cmd    = skt_pkg::CMD_DELETE;
          pos_next   = pos_ext[skt_pkg::POS_W-1:0];
          count_next = count - CW'(1);
        end else begin
          status_next = skt_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
    if (!eval) begin
      ctl.cmd    = skt_pkg::CMD_HOLD;
      count_next = count;
    end
  end

  assign cnt_ext = EW'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      m_tvalid <= 1'b0;
      count    <= '0;
    end else begin
      count <= count_next;
      if (s_tvalid && s_tready) begin
        busy <= 1'b1;
      end else if (eval) begin
        busy <= 1'b0;
      end
      if (eval) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_func     <= s_tuser;
      req_rec.key  <= s_tdata[23:0];
      req_rec.age  <= s_tdata[31:24];
      req_rec.kids <= s_tdata[39:32];
    end
    if (eval) begin
      out_status <= status_next;
      out_pos    <= pos_next;
      out_cnt    <= cnt_ext[skt_pkg::CNT_W-1:0];
    end
  end

  assign m_tuser = out_status;
  assign m_tdata = {5'd0, out_cnt, out_pos};

  // check that the fill count stays within capacity
  assert property (@(posedge clk) disable iff (rst) count <= CW'(CAPACITY))
    else $error("fill count above capacity");

  assert property (@(posedge clk) disable iff (rst) $onehot0(eqs))
    else $error("more than one slot matches the key");

  assert property (@(posedge clk) disable iff (rst) $onehot0(bounds))
    else $error("more than one insertion boundary");

  assert property (@(posedge clk) disable iff (rst)
    (eval && ctl.cmd == skt_pkg::CMD_INSERT) |=> count == $past(count) + CW'(1))
    else $error("insert did not advance the fill count");

  assert property (@(posedge clk) disable iff (rst)
    (busy && m_tvalid && !m_tready) |=> busy)
    else $error("request dropped while result stalled");

endmodule
